/* rtl/bta_pkg.sv */
// shared types, constants and helpers for the binary to ascii converter
// used by bta_ctrl, bta_datapath, binary_to_ascii_dec_hex and the verif benches; no dependencies
package bta_pkg;

    // field and storage widths
    localparam int VALUE_W     = 32;
    localparam int DIGIT_COUNT = 10;
    localparam int NIB_W       = 4;
    localparam int DIGIT_W     = $clog2(DIGIT_COUNT);
    localparam int CNT_W       = $clog2(VALUE_W);
    localparam int CHAR_W      = 7;
    localparam int DATA_W      = 8;
    localparam int BCD_W       = DIGIT_COUNT * NIB_W;

    // radix commands
    localparam logic CMD_DEC = 1'b0;
    localparam logic CMD_HEX = 1'b1;

    // ascii anchors
    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] ASCII_A     = 7'h61;
    localparam logic [CHAR_W-1:0] ASCII_A_OFS = ASCII_A - 7'd10;
    localparam logic [NIB_W-1:0]  DEC_LIMIT   = 4'd10;

    // controller to datapath commands
    typedef struct packed {
        logic               load;
        logic               hex;
        logic               shift;
        logic               emit;
        logic [DIGIT_W-1:0] sel;
        logic               final_digit;
    } dp_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic [DIGIT_W-1:0] msd;
        logic               out_free;
    } dp_status_t;

    // one digit to its ascii character
    function automatic logic [CHAR_W-1:0] nib_to_ascii(input logic [NIB_W-1:0] d);
        logic [CHAR_W-1:0] ext;
        ext = {{(CHAR_W-NIB_W){1'b0}}, d};
        if (d < DEC_LIMIT)
            return ASCII_ZERO + ext;
        else
            return ASCII_A_OFS + ext;
    endfunction

endpackage

/* rtl/bta_ctrl.sv */
// sequencer for the converter: load, double dabble shifts (decimal only), digit emission
// depends on bta_pkg
module bta_ctrl
    import bta_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic       start_hex,
    output logic       busy,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_PREP,
        ST_EMIT
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [DIGIT_W-1:0] idx_reg, idx_next;

    // next state and command decode
    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        idx_next        = idx_reg;
        cmd.load        = 1'b0;
        cmd.hex         = start_hex;
        cmd.shift       = 1'b0;
        cmd.emit        = 1'b0;
        cmd.sel         = idx_reg;
        cmd.final_digit = (idx_reg == '0);
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = (start_hex == CMD_HEX) ? ST_PREP : ST_CONVERT;
                end
            end
            ST_CONVERT:
            begin
                cmd.shift = 1'b1;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(VALUE_W - 1))
                    state_next = ST_PREP;
            end
            ST_PREP:
            begin
                // start at the most significant nonzero digit
                idx_next   = status.msd;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (idx_reg == '0)
                        state_next = ST_IDLE;
                    else
                        idx_next = idx_reg - 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

    // state and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            idx_reg   <= idx_next;
        end
    end

endmodule

/* rtl/bta_datapath.sv */
// value shift register, bcd digit register and output register
// depends on bta_pkg; driven by bta_ctrl commands
module bta_datapath
    import bta_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [VALUE_W-1:0] value,
    input  dp_cmd_t            cmd,
    output dp_status_t         status,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [DATA_W-1:0]  m_tdata,
    output logic               m_tlast
);

    logic [VALUE_W-1:0]                bin_reg, bin_next;
    logic [DIGIT_COUNT-1:0][NIB_W-1:0] bcd_reg, bcd_next;
    logic [DIGIT_COUNT-1:0][NIB_W-1:0] bcd_adj;
    logic [BCD_W-1:0]                  bcd_adj_flat;
    logic                              valid_reg, valid_next;
    logic [DATA_W-1:0]                 data_reg, data_next;
    logic                              last_reg, last_next;
    logic [DIGIT_W-1:0]                msd;

    // add-3 correction on every digit of at least five
    always_comb
    begin
        for (int i = 0; i < DIGIT_COUNT; i++)
            bcd_adj[i] = (bcd_reg[i] >= 4'd5) ? bcd_reg[i] + 4'd3 : bcd_reg[i];
    end

    // corrected digits as one flat vector for the shift
    assign bcd_adj_flat = bcd_adj;

    // load or shift the conversion registers
    always_comb
    begin
        bin_next = bin_reg;
        bcd_next = bcd_reg;
        if (cmd.load)
        begin
            bin_next = value;
            if (cmd.hex == CMD_HEX)
                bcd_next = {{(BCD_W-VALUE_W){1'b0}}, value};
            else
                bcd_next = '0;
        end
        else if (cmd.shift)
        begin
            bin_next = {bin_reg[VALUE_W-2:0], 1'b0};
            bcd_next = {bcd_adj_flat[BCD_W-2:0], bin_reg[VALUE_W-1]};
        end
    end

    // highest nonzero digit, zero when the whole value is zero
    always_comb
    begin
        msd = '0;
        for (int i = 0; i < DIGIT_COUNT; i++)
            if (bcd_reg[i] != '0)
                msd = DIGIT_W'(i);
    end

    assign status.msd      = msd;
    assign status.out_free = !valid_reg || m_tready;

    // output register
    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        last_next  = last_reg;
        if (cmd.emit)
        begin
            valid_next = 1'b1;
            data_next  = {{(DATA_W-CHAR_W){1'b0}}, nib_to_ascii(bcd_reg[cmd.sel])};
            last_next  = cmd.final_digit;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg  <= bin_next;
        bcd_reg  <= bcd_next;
        data_reg <= data_next;
        last_reg <= last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;

endmodule

/* rtl/binary_to_ascii_dec_hex.sv */
// Binary to ASCII converter, decimal or lowercase hexadecimal.
// Input stream: s_tdata carries a 32-bit unsigned value, s_tuser[0] selects the
// radix (0 decimal, 1 hex). Output stream: one request per digit, the ASCII
// character in m_tdata[6:0], most significant digit first, no leading zeros;
// m_tlast marks the least significant digit. Zero gives the single digit '0'.
// One value is converted at a time; s_tready is high only when idle.
// Decimal: a load, 32 bit-serial double dabble shifts, a setup step, then
// one digit per cycle while m_tready does not stall the output.
// Hex: a load, a setup step, then one digit per cycle under the same condition.
// The first digit passes from the setup state through the emit state into
// the output register before it appears on m_tvalid.
// A stall on m_tready holds the current digit in the output register and
// pauses emission; the next value is accepted once the last digit is loaded.
// Reset (rst_n low) clears the sequencer and the output valid flag.
// depends on bta_pkg, bta_ctrl, bta_datapath
module binary_to_ascii_dec_hex
    import bta_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [VALUE_W-1:0] s_tdata,   // [31:0] value
    input  logic [0:0]         s_tuser,   // [0] command
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [DATA_W-1:0]  m_tdata,   // [6:0] digit_char, [7] zero
    output logic               m_tlast
);

    dp_cmd_t    cmd;
    dp_status_t status;
    logic       busy;
    logic       start;

    // accept a request only when the sequencer is idle
    assign s_tready = !busy;
    assign start    = s_tvalid && s_tready;

    bta_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .start_hex (s_tuser[0]),
        .busy      (busy),
        .status    (status),
        .cmd       (cmd)
    );

    bta_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .value    (s_tdata),
        .cmd      (cmd),
        .status   (status),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // one value at a time
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> !s_tready)
        else $error("request accepted while a conversion was running");

    // a digit is loaded only into a free output register
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> status.out_free)
        else $error("digit loaded over a pending output");

    // every emitted character is a valid digit
    a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((m_tdata >= 8'h30 && m_tdata <= 8'h39) ||
                      (m_tdata >= 8'h61 && m_tdata <= 8'h66)))
        else $error("output character is not a digit");

endmodule

/* verif/bta_checker.sv */
// digit stream checker for the binary to ascii converter: watches both streams,
// predicts the digit characters of each accepted number and compares them in order
// depends on bta_pkg
`timescale 1ns / 100ps

module bta_checker
    import bta_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    input  logic               s_tready,
    input  logic [VALUE_W-1:0] s_tdata,   // [31:0] value
    input  logic [0:0]         s_tuser,   // [0] command
    input  logic               m_tvalid,
    input  logic               m_tready,
    input  logic [DATA_W-1:0]  m_tdata,   // [6:0] digit_char, [7] zero
    input  logic               m_tlast,
    output int                 mismatch_count,
    output int                 digits_due_count,
    output int                 digits_checked
);

    // ascii anchors for digits and lowercase letters
    localparam logic [CHAR_W-1:0] CH_DIGIT_BASE  = 7'h30;
    localparam logic [CHAR_W-1:0] CH_LETTER_BASE = 7'h61;
    localparam int                MAX_PRINTED    = 40;

    typedef struct packed {
        logic [CHAR_W-1:0] digit_char;
        logic              last;
    } digit_exp_t;

    digit_exp_t digits_due[$];

    initial
    begin
        mismatch_count   = 0;
        digits_checked   = 0;
        digits_due_count = 0;
    end

    // one line per mismatch, printing capped to keep the log short
    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatch_count < MAX_PRINTED)
            $display("%0t ns: digit mismatch on %s: got %0d, expected %0d",
                     $time, what, got, want);
        mismatch_count++;
    endtask

    // convert one number into its digit characters, most significant first
    function automatic void queue_digits(input logic [VALUE_W-1:0] num, input logic cmd);
        logic [VALUE_W-1:0] rest;
        logic [VALUE_W-1:0] radix;
        logic [VALUE_W-1:0] rem;
        logic [CHAR_W-1:0]  rev[$];
        digit_exp_t         e;
        radix = (cmd == CMD_HEX) ? 32'd16 : 32'd10;
        rest  = num;
        do
        begin
            rem = rest % radix;
            if (rem < 32'd10)
                rev.push_back(CH_DIGIT_BASE + CHAR_W'(rem));
            else
                rev.push_back(CH_LETTER_BASE + CHAR_W'(rem - 32'd10));
            rest = rest / radix;
        end
        while (rest != 0);
        for (int i = rev.size() - 1; i >= 0; i--)
        begin
            e.digit_char = rev[i];
            e.last       = (i == 0);
            digits_due.push_back(e);
        end
    endfunction

    // compare outgoing digits first, then predict from the accepted request
    always @(posedge clk)
    begin
        digit_exp_t e;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (digits_due.size() == 0)
                    report_mismatch("unexpected digit", m_tdata, 0);
                else
                begin
                    e = digits_due.pop_front();
                    if (m_tdata[CHAR_W-1:0] !== e.digit_char)
                        report_mismatch("digit_char", m_tdata[CHAR_W-1:0], e.digit_char);
                    if (m_tlast !== e.last)
                        report_mismatch("last", m_tlast, e.last);
                    if (m_tdata[DATA_W-1:CHAR_W] !== '0)
                        report_mismatch("tdata fill bit", m_tdata[DATA_W-1:CHAR_W], 0);
                    digits_checked++;
                end
            end
            if (s_tvalid && s_tready)
                queue_digits(s_tdata, s_tuser[0]);
            digits_due_count = digits_due.size();
        end
    end

endmodule

/* verif/testbench.sv */
// top of the binary to ascii converter testbench: clock, reset, number stimulus,
// output stall pattern and the verdict; depends on bta_pkg, bta_checker and the rtl
`timescale 1ns / 100ps

module testbench;
    import bta_pkg::*;

    localparam int RANDOM_ITEMS = 420;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 60;

    logic               clk;
    logic               rst_n;
    logic               s_tvalid;
    logic               s_tready;
    logic [VALUE_W-1:0] s_tdata;
    logic [0:0]         s_tuser;
    logic               m_tvalid;
    logic               m_tready;
    logic [DATA_W-1:0]  m_tdata;
    logic               m_tlast;

    int     mismatch_count;
    int     digits_due_count;
    int     digits_checked;
    int     numbers_sent;
    int     dec_numbers;
    int     hex_numbers;
    int     burst_left;
    logic   hold_off;
    logic [7:0] ready_phase;

    binary_to_ascii_dec_hex i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    bta_checker i_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .s_tvalid         (s_tvalid),
        .s_tready         (s_tready),
        .s_tdata          (s_tdata),
        .s_tuser          (s_tuser),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .m_tdata          (m_tdata),
        .m_tlast          (m_tlast),
        .mismatch_count   (mismatch_count),
        .digits_due_count (digits_due_count),
        .digits_checked   (digits_checked)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // overall time limit
    initial
    begin
        #10_000_000;
        $display("timeout with %0d digits still expected", digits_due_count);
        $display("Regression FAIL");
        $finish;
    end

    // output stall pattern, cycling through four behaviors
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready    <= 1'b0;
            ready_phase <= '0;
        end
        else
        begin
            ready_phase <= ready_phase + 8'd1;
            if (hold_off)
                m_tready <= 1'b0;
            else
            begin
                case (ready_phase[7:6])
                    2'd0:    m_tready <= 1'b1;
                    2'd1:    m_tready <= 1'($urandom_range(0, 1));
                    2'd2:    m_tready <= ($urandom_range(0, 4) != 0);
                    default: m_tready <= (ready_phase[3:0] < 4'd5);
                endcase
            end
        end
    end

    // long receiver hold-off while numbers keep being offered
    initial
    begin
        hold_off = 1'b0;
        wait (numbers_sent >= 150);
        @(negedge clk);
        hold_off = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_off = 1'b0;
    end

    // offer one number, wait for acceptance, then maybe go idle for a gap
    task automatic send_number(input logic [VALUE_W-1:0] num, input logic cmd,
                               input bit is_final);
        int gap;
        s_tdata  <= num;
        s_tuser  <= cmd;
        s_tvalid <= 1'b1;
        do
            @(negedge clk);
        while (!s_tready);
        @(posedge clk);
        numbers_sent++;
        if (cmd == CMD_HEX)
            hex_numbers++;
        else
            dec_numbers++;
        burst_left--;
        if (is_final)
            s_tvalid <= 1'b0;
        else if (burst_left <= 0)
        begin
            s_tvalid <= 1'b0;
            gap = $urandom_range(1, 12);
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 6);
        end
    endtask

    // random number with a random magnitude so short and long digit runs both occur
    function automatic logic [VALUE_W-1:0] pick_value();
        int nbits;
        nbits = $urandom_range(1, VALUE_W);
        if ($urandom_range(0, 3) == 0)
            return $urandom;
        return $urandom & (32'hFFFF_FFFF >> (VALUE_W - nbits));
    endfunction

    // stimulus
    initial
    begin
        logic [VALUE_W-1:0] edge_vals[$];
        logic               edge_cmds[$];
        logic               cmd;
        numbers_sent = 0;
        dec_numbers  = 0;
        hex_numbers  = 0;
        burst_left   = 3;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: zero, all ones, digit-count boundaries in both radixes
        edge_vals = '{32'd0, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd9, 32'd10,
                      32'd99, 32'd100, 32'd999_999_999, 32'd1_000_000_000,
                      32'h0000_000F, 32'h0000_0010, 32'h0FFF_FFFF, 32'h1000_0000,
                      32'hDEAD_BEEF, 32'hABCD_EF01, 32'd1, 32'd1, 32'h8000_0000,
                      32'h7FFF_FFFF, 32'd1_234_567_890, 32'h0123_4567};
        edge_cmds = '{CMD_DEC, CMD_HEX, CMD_DEC, CMD_HEX, CMD_DEC, CMD_DEC,
                      CMD_DEC, CMD_DEC, CMD_DEC, CMD_DEC,
                      CMD_HEX, CMD_HEX, CMD_HEX, CMD_HEX,
                      CMD_HEX, CMD_HEX, CMD_DEC, CMD_HEX, CMD_DEC,
                      CMD_HEX, CMD_DEC, CMD_HEX};
        foreach (edge_vals[i])
            send_number(edge_vals[i], edge_cmds[i], 1'b0);

        // random numbers in random radix
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            cmd = ($urandom_range(0, 1) == 1) ? CMD_HEX : CMD_DEC;
            send_number(pick_value(), cmd, n == RANDOM_ITEMS - 1);
        end

        // drain, once the checker has queued the last number
        @(posedge clk);
        wait (digits_due_count == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d numbers (%0d decimal, %0d hex), compared %0d digits",
                 numbers_sent, dec_numbers, hex_numbers, digits_checked);
        $display("covered zero, all ones, digit-count boundaries and a long output stall");
        if (digits_due_count != 0)
            $display("%0d expected digits never arrived", digits_due_count);
        if (mismatch_count == 0 && digits_due_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
